// ----- sv/ctst_pkg.sv -----
`timescale 1ns / 1ps
// ctst_pkg: shared types and constants for the compacting tile set table
// used by ctst_cell and compacting_tile_set_table; depends on nothing

package ctst_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W        = 32;
    localparam int SLOT_W       = 8;
    localparam int COUNT_W      = 9;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DEL = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] tile_key;
    } t_in_word;

    typedef struct packed {
        logic               done_res;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] entry_count;
    } t_out_word;

    // request token walking down the row of cells
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic              found;
        logic              was_empty;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_tok;

endpackage

// ----- sv/ctst_cell.sv -----
`timescale 1ns / 1ps
// ctst_cell: one table slot holding a key, plus the token stage that visits it
// depends on ctst_pkg

module ctst_cell
    import ctst_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tok             i_tok,
    input  logic [KEY_W-1:0] i_next_key,
    output t_tok             o_tok,
    output logic [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_same;
    logic             w_empty;

    assign w_same  = (r_key == i_tok.key);
    assign w_empty = (r_key == '0);

    always_comb begin
        n_key = r_key;
        n_tok = i_tok;
        if (i_tok.vld) begin
            case (i_tok.op)
                OP_ADD: begin
                    if (!i_tok.found && (w_same || w_empty)) begin
                        n_key           = i_tok.key;
                        n_tok.found     = 1'b1;
                        n_tok.was_empty = w_empty;
                        n_tok.slot      = SLOT_W'(IDX);
                    end
                end
                OP_DEL: begin
                    // once the key is hit, every later slot pulls from its neighbor
                    if (i_tok.found) begin
                        n_key = i_next_key;
                    end else if (w_same) begin
                        n_key       = i_next_key;
                        n_tok.found = 1'b1;
                        n_tok.slot  = SLOT_W'(IDX);
                    end
                end
                default: begin
                    n_key = r_key;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_key = r_key;

endmodule

// ----- sv/compacting_tile_set_table.sv -----
`timescale 1ns / 1ps
// compacting_tile_set_table: top level, a row of CAPACITY slot cells and the count
// depends on ctst_pkg and ctst_cell
//
// usage:
//   input channel i_in_valid / o_in_ready carries one request word: op (add or
//   delete) and tile_key. output channel o_out_valid / i_out_ready carries one
//   result word: done_res, slot and entry_count.
//   a request enters cell 0 on the accept edge and moves one cell per cycle;
//   each cell compares its own key and, for a delete, pulls the key of the next
//   cell from the matching cell onward. one request is in the row at a time, so
//   no new word is taken until the token has left the last cell and the
//   finished token is registered as the result.
//   o_in_ready also needs the output register empty or being drained, so a
//   stalled receiver holds off the next request; the held result stays put.
//   reset (synchronous, active low) clears every slot to empty, the count to
//   zero and both handshakes; the block is ready in the first cycle after it.

module compacting_tile_set_table
    import ctst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_tok                w_tok [0:CAPACITY];
    logic [KEY_W-1:0]    w_key [0:CAPACITY];
    logic [CAPACITY-1:0] w_vld;
    logic                w_accept;
    logic                w_done;
    t_tok                w_last;
    t_tok                w_head;

    logic                r_busy;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W+8:0]    w_cnt_ext;
    logic                r_out_valid;
    t_out_word           r_out_word;
    t_out_word           n_out_word;

    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_head     = '0;
        w_head.vld = w_accept;
        w_head.op  = i_in_word.op;
        w_head.key = i_in_word.tile_key;
    end

    assign w_tok[0]        = w_head;
    assign w_key[CAPACITY] = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        ctst_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[k]),
            .i_next_key (w_key[k+1]),
            .o_tok      (w_tok[k+1]),
            .o_key      (w_key[k])
        );
        assign w_vld[k] = w_tok[k+1].vld;
    end

    assign w_last = w_tok[CAPACITY];
    assign w_done = w_last.vld;

    always_comb begin
        n_count = r_count;
        if (w_done && w_last.found) begin
            case (w_last.op)
                OP_ADD: begin
                    if (w_last.was_empty && (w_last.key != '0)) begin
                        n_count = CNT_W'(r_count + 1'b1);
                    end
                end
                OP_DEL: begin
                    if ((w_last.key != '0) && (r_count != '0)) begin
                        n_count = CNT_W'(r_count - 1'b1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign w_cnt_ext = {9'd0, n_count};

    always_comb begin
        n_out_word.done_res    = w_last.found;
        n_out_word.slot        = w_last.found ? w_last.slot : '0;
        n_out_word.entry_count = w_cnt_ext[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            r_count <= n_count;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // at most one request word walks the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one token in the cell row");

    // a result never waits while a request is still in the row
    a_out_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_out_valid))
        else $error("output held while request in flight");

    // the token leaving the last cell lands in the output register
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_out_valid)
        else $error("finished token did not reach the output");

    // the entry count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count out of range");
`endif

endmodule
